// File: design/gcode_move_line_parser_macros.svh
// assertion macros shared by the checker module
// no dependencies
`ifndef GCODE_MOVE_LINE_PARSER_MACROS_SVH
`define GCODE_MOVE_LINE_PARSER_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define GMLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication checked outside reset
`define GMLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: design/gmlp_pkg.sv
// shared types, constants and helpers of the move line parser
// no dependencies
`default_nettype none
package gmlp_pkg;
	localparam int LINE_BYTES_DEF = 128;
	localparam int CfgIdxW = 2;
	localparam int QDEPTH = 4;

	localparam logic [1:0] ST_MOVE = 2'd0;
	localparam logic [1:0] ST_NO_E = 2'd1;
	localparam logic [1:0] ST_NO_XY = 2'd2;
	localparam logic [1:0] ST_NOT_MOVE = 2'd3;

	localparam logic [CfgIdxW-1:0] REG_ZOOM = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_OFFX = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_OFFY = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_OFFZ = 2'd3;

	// one parsed line handed from front to back
	typedef struct packed {
		logic is_move;
		logic [4:0] seen;
		logic [31:0] val_e;
		logic [31:0] val_f;
		logic [31:0] val_z;
		logic [31:0] val_x;
		logic [31:0] val_y;
	} line_t;

	// saturate a sign and magnitude to signed 32 bits
	function automatic logic [31:0] sat_mag(input logic neg, input logic [33:0] m);
		logic [31:0] r;
		if (!neg) r = (m > 34'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
		else if (m > 34'h80000000) r = 32'h80000000;
		else r = 32'd0 - m[31:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// File: design/gmlp_front.sv
// byte tokenizer and number parser, emits one parsed line per line end
// depends on gmlp_pkg
`default_nettype none
module gmlp_front #(
	parameter int LINE_BYTES = gmlp_pkg::LINE_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [7:0] line_byte,
	input wire logic line_end,
	output gmlp_pkg::line_t line_s1,
	output logic line_valid_s1
);
	localparam int PosW = $clog2(LINE_BYTES + 1);
	localparam logic [PosW-1:0] PosMax = PosW'(LINE_BYTES);
	// ceil(2^40 / 3125), exact for numerators below 2^28
	localparam logic [56:0] FbMagic = 57'd351843721;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_FIRST = 3'd1;
	localparam logic [2:0] PH_GAP = 3'd2;
	localparam logic [2:0] PH_SIGN = 3'd3;
	localparam logic [2:0] PH_INT = 3'd4;
	localparam logic [2:0] PH_FRAC = 3'd5;
	localparam logic [2:0] PH_SKIP = 3'd6;
	localparam logic [2:0] PH_HALT = 3'd7;

	logic [PosW-1:0] pos_q, pos_d;
	logic [2:0] phase_q, phase_d;
	logic [1:0] match_q, match_d;
	logic [2:0] letter_q, letter_d;
	logic [15:0] int_q, int_d;
	logic [16:0] frac_q, frac_d;
	logic [2:0] fcnt_q, fcnt_d;
	logic neg_q, neg_d;
	logic [4:0] seen_q, seen_d;
	logic [31:0] vals_q [5];
	logic [31:0] vals_d [5];

	// token state after the current byte, before any commit
	logic [2:0] step_letter;
	logic [15:0] step_int;
	logic [16:0] step_frac;
	logic [2:0] step_fcnt;
	logic step_neg;

	logic [16:0] f5;
	logic [27:0] fx;
	logic [56:0] fprod;
	logic [33:0] fb;
	logic [33:0] mag;
	logic [31:0] cval;
	logic [19:0] int_next;
	logic take, digit, commit;
	logic [3:0] dval;
	logic [2:0] new_letter;

	// fraction scaled to five digits, rounded to 1/65536
	always_comb begin
		unique case (step_fcnt)
			3'd0: f5 = 17'd0;
			3'd1: f5 = 17'(step_frac * 17'd10000);
			3'd2: f5 = 17'(step_frac * 17'd1000);
			3'd3: f5 = 17'(step_frac * 17'd100);
			3'd4: f5 = 17'(step_frac * 17'd10);
			default: f5 = step_frac;
		endcase
		// (f5 * 65536 + 50000) / 100000 equals (f5 * 2048 + 1562) / 3125
		fx = {f5, 11'd0} + 28'd1562;
		fprod = 57'(fx) * FbMagic;
		fb = {17'd0, fprod[56:40]};
		mag = {2'd0, step_int, 16'd0} + fb;
		cval = gmlp_pkg::sat_mag(step_neg, mag);
	end

	assign digit = line_byte >= 8'h30 && line_byte <= 8'h39;
	assign dval = line_byte[3:0];
	assign int_next = 20'(int_q * 20'd10) + 20'(dval);
	assign take = phase_q != PH_HALT && pos_q < PosMax;

	// token letter lookup, skipping letters already taken
	always_comb begin
		new_letter = 3'd0;
		unique case (line_byte)
			8'h45: if (!seen_q[0]) new_letter = 3'd1;
			8'h46: if (!seen_q[1]) new_letter = 3'd2;
			8'h5A: if (!seen_q[2]) new_letter = 3'd3;
			8'h58: if (!seen_q[3]) new_letter = 3'd4;
			8'h59: if (!seen_q[4]) new_letter = 3'd5;
			default: new_letter = 3'd0;
		endcase
	end

	// next state of the tokenizer
	always_comb begin
		pos_d = pos_q; phase_d = phase_q; match_d = match_q;
		step_letter = letter_q; step_int = int_q; step_frac = frac_q;
		step_fcnt = fcnt_q; step_neg = neg_q;
		commit = 1'b0;
		if (take) begin
			pos_d = pos_q + 1'b1;
			if (pos_q == '0 && line_byte == 8'h3B) begin
				phase_d = PH_HALT;
			end else if (line_byte == 8'h00) begin
				commit = 1'b1;
				phase_d = PH_HALT;
			end else if (line_byte == 8'h20) begin
				commit = 1'b1;
				if (phase_q != PH_START) phase_d = PH_GAP;
			end else begin
				unique case (phase_q)
					PH_START: begin
						match_d = (line_byte == 8'h47) ? 2'd1 : 2'd3;
						phase_d = PH_FIRST;
					end
					PH_FIRST: begin
						match_d = (match_q == 2'd1 &&
							(line_byte == 8'h30 || line_byte == 8'h31)) ? 2'd2 : 2'd3;
					end
					PH_GAP: begin
						step_letter = new_letter;
						phase_d = (new_letter != 3'd0) ? PH_SIGN : PH_SKIP;
					end
					PH_SIGN, PH_INT: begin
						if (phase_q == PH_SIGN && (line_byte == 8'h2B || line_byte == 8'h2D)) begin
							step_neg = line_byte == 8'h2D;
							phase_d = PH_INT;
						end else if (digit) begin
							step_int = (int_next > 20'd65535) ? 16'hFFFF : int_next[15:0];
							phase_d = PH_INT;
						end else if (line_byte == 8'h2E) begin
							phase_d = PH_FRAC;
						end else begin
							phase_d = PH_SKIP;
						end
					end
					PH_FRAC: begin
						if (digit) begin
							if (fcnt_q < 3'd5) begin
								step_frac = 17'(frac_q * 17'd10) + 17'(dval);
								step_fcnt = fcnt_q + 3'd1;
							end
						end else begin
							phase_d = PH_SKIP;
						end
					end
					default: ;
				endcase
			end
		end
		if (line_end) commit = 1'b1;
	end

	// close the open value
	always_comb begin
		letter_d = step_letter; int_d = step_int; frac_d = step_frac;
		fcnt_d = step_fcnt; neg_d = step_neg;
		seen_d = seen_q;
		for (int i = 0; i < 5; i++) vals_d[i] = vals_q[i];
		if (commit) begin
			if (step_letter != 3'd0) begin
				vals_d[step_letter - 3'd1] = cval;
				seen_d[step_letter - 3'd1] = 1'b1;
			end
			letter_d = '0; int_d = '0; frac_d = '0; fcnt_d = '0; neg_d = 1'b0;
		end
	end

	// tokenizer registers and line hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; phase_q <= PH_START; match_q <= '0; letter_q <= '0;
			int_q <= '0; frac_q <= '0; fcnt_q <= '0; neg_q <= 1'b0; seen_q <= '0;
			for (int i = 0; i < 5; i++) vals_q[i] <= '0;
			line_valid_s1 <= 1'b0;
		end else begin
			line_valid_s1 <= in_valid && line_end;
			if (in_valid) begin
				if (line_end) begin
					pos_q <= '0; phase_q <= PH_START; match_q <= '0; letter_q <= '0;
					int_q <= '0; frac_q <= '0; fcnt_q <= '0; neg_q <= 1'b0;
					seen_q <= '0;
					for (int i = 0; i < 5; i++) vals_q[i] <= '0;
				end else begin
					pos_q <= pos_d; phase_q <= phase_d; match_q <= match_d;
					letter_q <= letter_d; int_q <= int_d; frac_q <= frac_d;
					fcnt_q <= fcnt_d; neg_q <= neg_d; seen_q <= seen_d;
					for (int i = 0; i < 5; i++) vals_q[i] <= vals_d[i];
				end
			end
		end
	end

	// parsed line payload
	always_ff @(posedge clk) begin
		if (in_valid && line_end) begin
			line_s1.is_move <= match_d == 2'd2;
			line_s1.seen <= seen_d;
			line_s1.val_e <= vals_d[0];
			line_s1.val_f <= vals_d[1];
			line_s1.val_z <= vals_d[2];
			line_s1.val_x <= vals_d[3];
			line_s1.val_y <= vals_d[4];
		end
	end
endmodule
`default_nettype wire

// File: design/gmlp_queue.sv
// small queue of parsed lines between front and back
// depends on gmlp_pkg
`default_nettype none
module gmlp_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input gmlp_pkg::line_t wr_data,
	input wire logic rd_en,
	output gmlp_pkg::line_t rd_data,
	output logic not_empty,
	output logic [$clog2(gmlp_pkg::QDEPTH+1)-1:0] count
);
	localparam int AW = $clog2(gmlp_pkg::QDEPTH);
	gmlp_pkg::line_t mem_q [gmlp_pkg::QDEPTH];
	logic [AW-1:0] wp_q, rp_q;

	assign rd_data = mem_q[rp_q];
	assign not_empty = count != '0;

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; count <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
			count <= count + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
		end
	end
endmodule
`default_nettype wire

// File: design/gmlp_back.sv
// applies a parsed line to the modal values and scales the targets
// depends on gmlp_pkg
`default_nettype none
module gmlp_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic [gmlp_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic q_avail,
	input gmlp_pkg::line_t q_line,
	output logic q_take,
	input wire logic pop,
	output logic empty,
	output logic [1:0] status,
	output logic [31:0] target_x,
	output logic [31:0] target_y,
	output logic [31:0] target_z,
	output logic [31:0] feed_rate,
	output logic [31:0] extrude_amount
);
	logic [31:0] zoom_q, offx_q, offy_q, offz_q;
	logic [31:0] mod_e_q, mod_f_q, mod_z_q;
	logic v_s1, v_s2;
	logic [1:0] st_s1;
	logic [32:0] dx_s1, dy_s1, dz_s1;
	logic [31:0] f_s1, e_s1;
	logic [65:0] px_s2, py_s2, pz_s2;
	logic [1:0] st_s2;
	logic [31:0] f_s2, e_s2;
	logic out_v_q;
	logic adv;
	logic [31:0] ne, nf, nz;
	logic [1:0] nst;

	// round to nearest with ties away from zero, then saturate
	function automatic logic [31:0] scale(input logic [65:0] p);
		logic [65:0] m;
		logic [65:0] r;
		m = p[65] ? 66'd0 - p : p;
		r = (m + 66'h8000) >> 16;
		return gmlp_pkg::sat_mag(p[65], (r[65:34] != '0) ? 34'h3FFFFFFFF : r[33:0]);
	endfunction

	// the result register and both stages move together
	assign adv = !out_v_q || pop;
	assign q_take = q_avail && adv;
	assign empty = !out_v_q;

	// modal update for the line at the queue head
	always_comb begin
		ne = mod_e_q; nf = mod_f_q; nz = mod_z_q;
		if (!q_line.is_move) begin
			nst = gmlp_pkg::ST_NOT_MOVE;
		end else if (!q_line.seen[0]) begin
			ne = '0;
			nst = gmlp_pkg::ST_NO_E;
		end else begin
			ne = q_line.val_e;
			if (q_line.seen[1]) nf = q_line.val_f;
			if (q_line.seen[2]) nz = q_line.val_z;
			nst = (q_line.seen[4:3] == 2'b11) ? gmlp_pkg::ST_MOVE : gmlp_pkg::ST_NO_XY;
		end
	end

	// configuration and modal registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q <= 32'h00010000; offx_q <= '0; offy_q <= '0; offz_q <= '0;
			mod_e_q <= '0; mod_f_q <= '0; mod_z_q <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; out_v_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					gmlp_pkg::REG_ZOOM: zoom_q <= cfg_data;
					gmlp_pkg::REG_OFFX: offx_q <= cfg_data;
					gmlp_pkg::REG_OFFY: offy_q <= cfg_data;
					gmlp_pkg::REG_OFFZ: offz_q <= cfg_data;
				endcase
			end
			if (q_take) begin
				mod_e_q <= ne; mod_f_q <= nf; mod_z_q <= nz;
			end
			if (adv) begin
				v_s1 <= q_take;
				v_s2 <= v_s1;
				out_v_q <= v_s2;
			end
		end
	end

	// stage 1 offset subtraction, stage 2 multiply, then round and saturate
	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= nst;
			dx_s1 <= {q_line.val_x[31], q_line.val_x} - {offx_q[31], offx_q};
			dy_s1 <= {q_line.val_y[31], q_line.val_y} - {offy_q[31], offy_q};
			dz_s1 <= {nz[31], nz} - {offz_q[31], offz_q};
			f_s1 <= nf; e_s1 <= ne;
			px_s2 <= 66'($signed(dx_s1) * $signed(zoom_q));
			py_s2 <= 66'($signed(dy_s1) * $signed(zoom_q));
			pz_s2 <= 66'($signed(dz_s1) * $signed(zoom_q));
			st_s2 <= st_s1; f_s2 <= f_s1; e_s2 <= e_s1;
			status <= st_s2;
			target_x <= (st_s2 == gmlp_pkg::ST_MOVE) ? scale(px_s2) : '0;
			target_y <= (st_s2 == gmlp_pkg::ST_MOVE) ? scale(py_s2) : '0;
			target_z <= (st_s2 == gmlp_pkg::ST_MOVE) ? scale(pz_s2) : '0;
			feed_rate <= f_s2; extrude_amount <= e_s2;
		end
	end
endmodule
`default_nettype wire

// File: design/gcode_move_line_parser.sv
// G0/G1 move line parser: byte front end, line queue and scaling back end
// depends on gmlp_pkg, gmlp_front, gmlp_queue, gmlp_back
// a line result passes the front line register, the queue and 3 back stages
// throughput: one byte per cycle while full is low; one line result per cycle at most
// reset clears parse state, modal values and queue; zoom resets to 1.0, offsets to 0
`default_nettype none
module gcode_move_line_parser #(
	parameter int LINE_BYTES = gmlp_pkg::LINE_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [7:0] line_byte,
	input wire logic line_end,
	output logic empty,
	input wire logic pop,
	output logic [1:0] status,
	output logic [31:0] target_x,
	output logic [31:0] target_y,
	output logic [31:0] target_z,
	output logic [31:0] feed_rate,
	output logic [31:0] extrude_amount,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [gmlp_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	gmlp_pkg::line_t line_s1, q_line;
	logic line_valid_s1, q_avail, q_take, in_acc;
	logic [$clog2(gmlp_pkg::QDEPTH+1)-1:0] q_count;

	assign cfg_ready = 1'b1;
	// hold input when the queue could overflow counting the line in flight
	assign full = q_count >= $bits(q_count)'(gmlp_pkg::QDEPTH - 1);
	assign in_acc = push && !full;

	gmlp_front #(.LINE_BYTES(LINE_BYTES)) u_front (
		.clk, .arst_n, .in_valid(in_acc), .line_byte, .line_end,
		.line_s1, .line_valid_s1
	);

	gmlp_queue u_queue (
		.clk, .arst_n, .wr_en(line_valid_s1), .wr_data(line_s1),
		.rd_en(q_take), .rd_data(q_line), .not_empty(q_avail), .count(q_count)
	);

	gmlp_back u_back (
		.clk, .arst_n, .cfg_valid, .cfg_index, .cfg_data,
		.q_avail, .q_line, .q_take, .pop, .empty,
		.status, .target_x, .target_y, .target_z, .feed_rate, .extrude_amount
	);
endmodule
`default_nettype wire

// File: design/gmlp_checker.sv
// port-level checks of the move line parser, bound to the top level
// depends on gcode_move_line_parser_macros.svh
`default_nettype none
`include "gcode_move_line_parser_macros.svh"
module gmlp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic empty,
	input wire logic pop,
	input wire logic [1:0] status,
	input wire logic [31:0] target_x,
	input wire logic [31:0] target_y
);
	`GMLP_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(status), "result dropped")
	`GMLP_ASSERT_IMP(a_zx, clk, arst_n, !empty && status != 2'd0, target_x == 32'd0, "x not zero")
	`GMLP_ASSERT_IMP(a_zy, clk, arst_n, !empty && status != 2'd0, target_y == 32'd0, "y not zero")
endmodule

bind gcode_move_line_parser gmlp_checker u_checker (
	.clk, .arst_n, .empty, .pop, .status, .target_x, .target_y
);
`default_nettype wire

// File: test/gcode_move_line_parser_tb.sv
// self-checking bench for the G0/G1 move line parser: byte items in, line results out
// depends on gmlp_pkg and gcode_move_line_parser; carries its own line predictor
`default_nettype none
module gcode_move_line_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_LEN = 128;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef enum logic [2:0] {
		P_START, P_FIRST, P_GAP, P_SIGN, P_INT, P_FRAC, P_SKIP, P_HALT
	} phase_e;

	typedef struct packed {
		logic [1:0] st;
		logic [31:0] tx, ty, tz, feed, ext;
	} line_result_t;

	// line predictor plus queue of expected results
	class move_scoreboard;
		logic [31:0] zoom, offx, offy, offz;
		int unsigned pos;
		phase_e ph;
		int unsigned match, letter, ia, fa, fcnt;
		bit neg;
		logic [4:0] seen;
		logic [31:0] lval[5];
		logic [31:0] modal[5];
		line_result_t pending[$];
		int errors;

		function void reset_all();
			zoom = 32'h10000; offx = 0; offy = 0; offz = 0;
			foreach (modal[i]) modal[i] = 0;
			errors = 0;
			clear_line();
		endfunction

		function void write_reg(logic [gmlp_pkg::CfgIdxW-1:0] idx, logic [31:0] v);
			case (idx)
				gmlp_pkg::REG_ZOOM: zoom = v;
				gmlp_pkg::REG_OFFX: offx = v;
				gmlp_pkg::REG_OFFY: offy = v;
				gmlp_pkg::REG_OFFZ: offz = v;
			endcase
		endfunction

		function void clear_token();
			letter = 0; ia = 0; fa = 0; fcnt = 0; neg = 0;
		endfunction

		function void clear_line();
			pos = 0; ph = P_START; match = 0; seen = 0;
			clear_token();
			foreach (lval[i]) lval[i] = 0;
		endfunction

		function logic [31:0] sat(bit n, longint unsigned m);
			if (!n) return (m > 64'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
			if (m > 64'h80000000) return 32'h80000000;
			return 32'd0 - m[31:0];
		endfunction

		function void commit();
			longint unsigned f5, fb, mag, p10;
			if (letter != 0) begin
				p10 = 1;
				for (int i = fcnt; i < 5; i++) p10 *= 10;
				f5 = longint'(fa) * p10;
				fb = (f5 * 65536 + 50000) / 100000;
				mag = (longint'(ia) << 16) + fb;
				lval[letter-1] = sat(neg, mag);
				seen[letter-1] = 1'b1;
			end
			clear_token();
		endfunction

		function void take(logic [7:0] c);
			bit dig;
			byte codes[5];
			codes = '{"E", "F", "Z", "X", "Y"};
			dig = c >= "0" && c <= "9";
			if (pos == 0 && c == ";") begin
				ph = P_HALT;
				return;
			end
			if (c == 0) begin
				commit(); ph = P_HALT;
				return;
			end
			if (c == " ") begin
				commit();
				if (ph != P_START) ph = P_GAP;
				return;
			end
			case (ph)
				P_START: begin
					match = (c == "G") ? 1 : 3;
					ph = P_FIRST;
				end
				P_FIRST: match = (match == 1 && (c == "0" || c == "1")) ? 2 : 3;
				P_GAP: begin
					ph = P_SKIP;
					for (int i = 0; i < 5; i++)
						if (c == codes[i] && !seen[i]) begin
							letter = i + 1; ph = P_SIGN;
						end
				end
				P_SIGN, P_INT: begin
					if (ph == P_SIGN && (c == "+" || c == "-")) begin
						neg = (c == "-"); ph = P_INT;
					end else if (dig) begin
						ia = ia * 10 + (c - "0");
						if (ia > 65535) ia = 65535;
						ph = P_INT;
					end else if (c == ".") ph = P_FRAC;
					else ph = P_SKIP;
				end
				P_FRAC: begin
					if (dig) begin
						if (fcnt < 5) begin
							fa = fa * 10 + (c - "0"); fcnt++;
						end
					end else ph = P_SKIP;
				end
				default: ;
			endcase
		endfunction

		function logic [31:0] scale(logic [31:0] coord, logic [31:0] offs);
			longint p;
			longint unsigned m;
			bit n;
			p = (longint'(signed'(coord)) - longint'(signed'(offs))) * longint'(signed'(zoom));
			n = p < 0;
			m = n ? -p : p;
			m = (m + 64'h8000) >> 16;
			return sat(n, m);
		endfunction

		// note one accepted byte item
		function void note_byte(logic [7:0] c, logic last);
			line_result_t r;
			if (ph != P_HALT && pos < LINE_LEN) begin
				take(c); pos++;
			end
			if (!last) return;
			commit();
			r = '0;
			if (match != 2) r.st = gmlp_pkg::ST_NOT_MOVE;
			else if (!seen[0]) begin
				modal[0] = 0; r.st = gmlp_pkg::ST_NO_E;
			end else begin
				modal[0] = lval[0];
				if (seen[1]) modal[1] = lval[1];
				if (seen[2]) modal[2] = lval[2];
				if (seen[4:3] != 2'b11) r.st = gmlp_pkg::ST_NO_XY;
				else begin
					modal[3] = lval[3]; modal[4] = lval[4];
					r.tx = scale(lval[3], offx);
					r.ty = scale(lval[4], offy);
					r.tz = scale(modal[2], offz);
					r.st = gmlp_pkg::ST_MOVE;
				end
			end
			r.feed = modal[1];
			r.ext = modal[0];
			pending.push_back(r);
			clear_line();
		endfunction

		// compare one accepted result with the oldest expectation
		function void check(line_result_t got);
			line_result_t exp_r;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				errors++;
				if (errors <= 10)
					$display("result differs: exp st=%0d x=%h y=%h z=%h f=%h e=%h, got st=%0d x=%h y=%h z=%h f=%h e=%h",
						exp_r.st, exp_r.tx, exp_r.ty, exp_r.tz, exp_r.feed, exp_r.ext,
						got.st, got.tx, got.ty, got.tz, got.feed, got.ext);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic push = 0, pop = 0, line_end = 0;
	logic [7:0] line_byte = 0;
	logic cfg_valid = 0;
	logic [gmlp_pkg::CfgIdxW-1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	logic full, empty, cfg_ready;
	logic [1:0] status;
	logic [31:0] target_x, target_y, target_z, feed_rate, extrude_amount;
	longint cycles = 0;
	int stall_mode = 0;
	int burst_left = 0;
	move_scoreboard sb;

	gcode_move_line_parser i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.line_byte(line_byte), .line_end(line_end), .empty(empty), .pop(pop),
		.status(status), .target_x(target_x), .target_y(target_y),
		.target_z(target_z), .feed_rate(feed_rate), .extrude_amount(extrude_amount),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: check accepted items, stall on a shifting pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check({status, target_x, target_y, target_z, feed_rate, extrude_amount});
			case (stall_mode)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 3) != 0);
				2: pop <= (cycles % 7) < 2;
				default: pop <= ($urandom_range(0, 9) == 0);
			endcase
			if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
		end
	end

	// send one byte item, with bursty gaps
	task automatic send_byte(logic [7:0] c, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		push <= 1'b1;
		line_byte <= c;
		line_end <= last;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_byte(c, last);
	endtask

	task automatic send_line(string s, logic close = 1'b1);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], close && i == s.len() - 1);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [gmlp_pkg::CfgIdxW-1:0] idx, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, v);
		@(posedge clk);
	endtask

	function automatic string rand_num();
		string s;
		int k;
		s = "";
		k = $urandom_range(0, 5);
		if (k == 0) s = "-";
		else if (k == 1) s = "+";
		k = $urandom_range(0, 7);
		if (k == 7) s = {s, "99999"};
		else if (k == 6) s = {s, "65535"};
		else s = {s, $sformatf("%0d", $urandom_range(0, 300))};
		if ($urandom_range(0, 2) != 0) begin
			s = {s, "."};
			k = $urandom_range(0, 7);
			for (int i = 0; i < k; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		end
		return s;
	endfunction

	// mostly well formed move lines with random fields, some noise
	function automatic string rand_line();
		string s;
		byte letters[7];
		int n;
		letters = '{"E", "F", "Z", "X", "Y", "Q", "G"};
		case ($urandom_range(0, 9))
			0: begin
				n = $urandom_range(1, 12);
				s = "";
				for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(0, 255)))};
				return s;
			end
			1: s = ";G1 X1 Y1 E1";
			2: s = $urandom_range(0, 1) ? "G2" : "M104";
			default: s = $urandom_range(0, 1) ? "G1" : "G0";
		endcase
		n = $urandom_range(0, 8);
		for (int i = 0; i < n; i++) begin
			s = {s, " ", string'(letters[$urandom_range(0, 6)]), rand_num()};
			if ($urandom_range(0, 15) == 0) s = {s, "abc"};
			if ($urandom_range(0, 20) == 0) s = {s, " "};
		end
		if ($urandom_range(0, 2) != 0)
			s = {s, " E", rand_num(), " X", rand_num(), " Y", rand_num()};
		if ($urandom_range(0, 30) == 0) s = {s, string'(byte'(0)), " X5"};
		if ($urandom_range(0, 40) == 0)
			for (int i = 0; i < 140; i++) s = {s, "7"};
		return s;
	endfunction

	function automatic logic [31:0] rand_reg();
		case ($urandom_range(0, 4))
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return $urandom_range(0, 1) ? 32'h10000 : 32'hFFFF0000;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int sent;
		sb = new();
		sb.reset_all();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines: extremes, special cases, every status
		send_line("G1 X1.5 Y-2.25 Z3 F1200 E0.5");
		send_line("G0 X99999.999999 Y-99999 E+1.00001 Z-0.000005");
		send_line("G1 X1 Y2");
		send_line("G1 E1 X3");
		send_line("G1 E2 F5");
		send_line(";G1 X1 Y1 E1");
		send_line("M3 X1 Y1 E1");
		send_line("G10 X1 Y1 E1");
		send_line("");
		send_line(" ");
		send_line("G1 X7 X8 Y1 Y2 E3 E4 Zq F-");
		send_line("G1 E1 X2", 1'b0);
		send_byte(8'h00, 1'b0);
		send_line(" Y3");
		send_line("G1 E.5 X. Y-. Z65535.99999 F65536");
		send_line("G1 E1 X0.000007 Y0.999995 Zabc");
		send_line("G1 E1 X2 Y");
		send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b1);
		drain();

		// register extremes
		write_reg(gmlp_pkg::REG_ZOOM, 32'h7FFFFFFF);
		write_reg(gmlp_pkg::REG_OFFX, 32'h80000000);
		write_reg(gmlp_pkg::REG_OFFY, 32'h7FFFFFFF);
		write_reg(gmlp_pkg::REG_OFFZ, 32'h80000000);
		send_line("G1 E1 X-65535 Y65535 Z1");
		send_line("G1 E1 X65535 Y-65535 Z-65535");
		drain();
		write_reg(gmlp_pkg::REG_ZOOM, 32'h80000000);
		send_line("G0 E1 X3 Y-3 Z1");
		drain();

		// random phases with fresh register settings
		sent = 0;
		while (sent < 1600) begin
			for (int r = 0; r < 4; r++) write_reg(r[gmlp_pkg::CfgIdxW-1:0], rand_reg());
			for (int l = 0; l < 40 && sent < 1600; l++) begin
				string s;
				s = rand_line();
				send_line(s);
				sent += s.len();
			end
			drain();
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
